// ===== rtl/core/txs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// txs_pkg
// Shared types and constants for the mapper 118 bank and IRQ block.
// ----------------------------------------------------------------------------
package txs_pkg;
    localparam int unsigned CFG_WIDTH = 8;
    localparam int unsigned CFG_INDEX_WIDTH = 1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PRG_COUNT = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CHR_COUNT = 1'b1;

    localparam logic [15:0] ADDR_MASK      = 16'hE001;
    localparam logic [15:0] ADDR_BANK_SEL  = 16'h8000;
    localparam logic [15:0] ADDR_BANK_DATA = 16'h8001;
    localparam logic [15:0] ADDR_IRQ_LATCH = 16'hC000;
    localparam logic [15:0] ADDR_IRQ_RELOAD = 16'hC001;
    localparam logic [15:0] ADDR_IRQ_OFF   = 16'hE000;
    localparam logic [15:0] ADDR_IRQ_ON    = 16'hE001;
    localparam logic [8:0]  LAST_VISIBLE   = 9'd239;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [15:0] cpu_address;
        logic [7:0]  write_data;
        logic [8:0]  scanline;
        logic        rendering_enabled;
    } t_req;

    typedef struct packed {
        logic [35:0] prg_page_map;
        logic [43:0] chr_page_map_low;
        logic [43:0] chr_page_map_high;
        logic        mirror_mode;
        logic        irq_request;
    } t_rsp;
endpackage
`default_nettype wire

// ===== rtl/core/txs_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// txs_req_if
// Valid/ready channel carrying one mapper request transaction.
// ----------------------------------------------------------------------------
interface txs_req_if import txs_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/txs_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// txs_rsp_if
// Valid/ready channel carrying one resolved page map transaction.
// ----------------------------------------------------------------------------
interface txs_rsp_if import txs_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/nes_txsrom_bank_irq_mapper.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nes_txsrom_bank_irq_mapper
// Mapper 118 register file, scanline IRQ counter and page map resolver.
// ----------------------------------------------------------------------------
// channel  | dir | payload
// i_req    | in  | req_type, cpu_address, write_data, scanline, rendering_enabled
// o_rsp    | out | prg_page_map, chr_page_map_low/high, mirror_mode, irq_request
// cfg      | in  | i_cfg_we, i_cfg_index, i_cfg_data
//
// One transaction: the update at the accepting edge, then 10 bank reductions
// through one shared restoring-remainder unit (a load step, then one step per
// dividend bit each), then the ST_DONE output step. No new request is taken
// until the whole transaction is through.
// The remainder unit is the bottleneck. Synchronous active-low reset.
// Input is not taken while a result waits in the output register.
// ----------------------------------------------------------------------------
module nes_txsrom_bank_irq_mapper import txs_pkg::*; (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  wire logic [CFG_WIDTH-1:0]       i_cfg_data,
    txs_req_if.sink                         i_req,
    txs_rsp_if.source                       o_rsp
);
    typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_DIV, ST_DONE} t_state;

    t_state      r_state;
    logic [7:0]  r_cfg_prg, r_cfg_chr;
    logic [7:0]  r_bank_select, r_prg_first, r_prg_second, r_irq_counter, r_irq_reload;
    logic [7:0]  r_chr [8];
    logic        r_irq_en, r_mirror, r_irq;
    logic [3:0]  r_job;
    logic [2:0]  r_bit;
    logic [7:0]  r_dividend;
    logic [10:0] r_rem;
    logic [10:0] r_res [10];
    logic        r_out_valid;
    t_rsp        r_out;

    t_req        w_req;
    logic [15:0] w_dec;
    logic [2:0]  w_sel;
    logic [7:0]  w_pair;
    logic [10:0] w_div, w_shift, w_sub;
    logic [8:0]  w_p;
    logic [10:0] w_c;
    logic [7:0]  w_src;
    logic [2:0]  w_entry;

    assign w_req = i_req.data;
    assign w_dec = w_req.cpu_address & ADDR_MASK;
    assign w_sel = r_bank_select[2:0];
    assign w_pair = w_req.write_data & 8'hFE;
    assign w_p = {r_cfg_prg, 1'b0};
    assign w_c = {r_cfg_chr, 3'b000};
    assign i_req.ready = (r_state == ST_IDLE) && !r_out_valid;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data = r_out;

    // jobs 0,1: PRG first/second; jobs 2..9: CHR slots 0..7
    always_comb begin
        w_entry = r_job[2:0] - 3'd2;
        if (r_bank_select[7]) begin
            w_entry = w_entry ^ 3'd4;
        end
        case (r_job)
            4'd0:    w_src = r_prg_first;
            4'd1:    w_src = r_prg_second;
            default: w_src = r_chr[w_entry];
        endcase
        w_div = (r_job < 4'd2) ? {2'b00, w_p} : w_c;
        w_shift = {r_rem[9:0], r_dividend[7]};
        w_sub = w_shift - w_div;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cfg_prg <= 8'd2;
            r_cfg_chr <= 8'd0;
            r_bank_select <= 8'd0;
            r_prg_first <= 8'd0;
            r_prg_second <= 8'd1;
            for (int i = 0; i < 8; i++) begin
                r_chr[i] <= 8'(i);
            end
            r_irq_en <= 1'b0;
            r_irq_counter <= 8'd0;
            r_irq_reload <= 8'd0;
            r_mirror <= 1'b0;
            r_irq <= 1'b0;
            r_out_valid <= 1'b0;
            r_job <= 4'd0;
            r_bit <= 3'd0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_PRG_COUNT) begin
                    r_cfg_prg <= i_cfg_data;
                end else begin
                    r_cfg_chr <= i_cfg_data;
                end
            end
            if (o_rsp.valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_req.valid && i_req.ready) begin
                        r_irq <= 1'b0;
                        r_job <= 4'd0;
                        r_state <= ST_LOAD;
                        if (w_req.req_type == REQ_WRITE) begin
                            case (w_dec)
                                ADDR_BANK_SEL: r_bank_select <= w_req.write_data;
                                ADDR_BANK_DATA: begin
                                    if (w_sel < 3'd6) begin
                                        r_mirror <= ~w_req.write_data[7];
                                    end
                                    if (w_sel < 3'd2) begin
                                        if (r_cfg_chr != 8'd0) begin
                                            r_chr[{1'b0, w_sel[0], 1'b0}] <= w_pair;
                                            r_chr[{1'b0, w_sel[0], 1'b1}] <= w_pair + 8'd1;
                                        end
                                    end else if (w_sel < 3'd6) begin
                                        if (r_cfg_chr != 8'd0) begin
                                            r_chr[w_sel + 3'd2] <= w_req.write_data;
                                        end
                                    end else if (w_sel == 3'd6) begin
                                        r_prg_first <= w_req.write_data;
                                    end else begin
                                        r_prg_second <= w_req.write_data;
                                    end
                                end
                                ADDR_IRQ_LATCH: r_irq_counter <= w_req.write_data;
                                ADDR_IRQ_RELOAD: r_irq_reload <= w_req.write_data;
                                ADDR_IRQ_OFF: r_irq_en <= 1'b0;
                                ADDR_IRQ_ON: r_irq_en <= 1'b1;
                                default: ;
                            endcase
                        end else if (r_irq_en && w_req.scanline <= LAST_VISIBLE
                                     && w_req.rendering_enabled) begin
                            if (r_irq_counter == 8'd0) begin
                                r_irq_counter <= r_irq_reload;
                                r_irq <= 1'b1;
                            end else begin
                                r_irq_counter <= r_irq_counter - 8'd1;
                            end
                        end
                    end
                end
                ST_LOAD: begin
                    r_dividend <= w_src;
                    r_rem <= 11'd0;
                    r_bit <= 3'd0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_dividend <= {r_dividend[6:0], 1'b0};
                    r_rem <= (w_shift >= w_div) ? w_sub : w_shift;
                    r_bit <= r_bit + 3'd1;
                    if (r_bit == 3'd7) begin
                        r_res[r_job] <= (w_shift >= w_div) ? w_sub : w_shift;
                        if (r_job == 4'd9) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_job <= r_job + 4'd1;
                            r_state <= ST_LOAD;
                        end
                    end
                end
                ST_DONE: begin
                    r_out_valid <= 1'b1;
                    r_out.mirror_mode <= r_mirror;
                    r_out.irq_request <= r_irq;
                    if (w_p == 9'd0) begin
                        r_out.prg_page_map <= 36'd0;
                    end else if (r_bank_select[6]) begin
                        r_out.prg_page_map <= {w_p - 9'd1, r_res[0][8:0],
                                               r_res[1][8:0], w_p - 9'd2};
                    end else begin
                        r_out.prg_page_map <= {w_p - 9'd1, w_p - 9'd2,
                                               r_res[1][8:0], r_res[0][8:0]};
                    end
                    if (w_c == 11'd0) begin
                        r_out.chr_page_map_low <= 44'd0;
                        r_out.chr_page_map_high <= 44'd0;
                    end else begin
                        r_out.chr_page_map_low <= {r_res[5], r_res[4], r_res[3], r_res[2]};
                        r_out.chr_page_map_high <= {r_res[9], r_res[8], r_res[7], r_res[6]};
                    end
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Mapper 118 bank/IRQ testbench. Register writes and scanline ticks are sent
// over the request channel, each result is checked against an in-bench model
// of the bank registers, IRQ counter and page map resolution.
// ----------------------------------------------------------------------------
module tb_top;
    import txs_pkg::*;

    localparam int MAX_CYCLES = 2_000_000;
    localparam int DRAIN_CYCLES = 200;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] i_cfg_index = '0;
    logic [CFG_WIDTH-1:0] i_cfg_data = '0;

    txs_req_if req_ch ();
    txs_rsp_if rsp_ch ();

    nes_txsrom_bank_irq_mapper i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_req(req_ch.sink), .o_rsp(rsp_ch.source)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // mapper model state
    logic [7:0] m_prg_count, m_chr_count;
    logic [7:0] m_bank_sel, m_prg_first, m_prg_second;
    logic [7:0] m_chr_bank [8];
    logic       m_irq_en, m_mirror;
    logic [7:0] m_irq_cnt, m_irq_reload;

    t_rsp expected_maps [$];
    int   n_errors = 0;
    int   n_checked = 0;
    int   n_irqs = 0;
    int   cycle_count = 0;
    int   hold_off = 0;
    bit   stall_enable = 1'b1;

    initial begin
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b0;
    end

    task automatic model_reset();
        m_prg_count = 8'd2;
        m_chr_count = 8'd0;
        m_bank_sel = '0;
        m_prg_first = '0;
        m_prg_second = 8'd1;
        for (int i = 0; i < 8; i++) m_chr_bank[i] = i[7:0];
        m_irq_en = 1'b0;
        m_irq_cnt = '0;
        m_irq_reload = '0;
        m_mirror = 1'b0;
    endtask

    function automatic t_rsp resolve_maps(input logic irq);
        t_rsp r;
        int unsigned p, c, pg;
        int unsigned s [4];
        int entry;
        r = '0;
        p = 2 * m_prg_count;
        c = 8 * m_chr_count;
        if (p != 0) begin
            if (m_bank_sel[6]) begin
                s[0] = p - 2;
                s[1] = m_prg_second % p;
                s[2] = m_prg_first % p;
            end else begin
                s[0] = m_prg_first % p;
                s[1] = m_prg_second % p;
                s[2] = p - 2;
            end
            s[3] = p - 1;
            for (int i = 0; i < 4; i++) r.prg_page_map[9*i +: 9] = s[i][8:0];
        end
        if (c != 0) begin
            for (int i = 0; i < 8; i++) begin
                entry = m_bank_sel[7] ? (i ^ 4) : i;
                pg = m_chr_bank[entry] % c;
                if (i < 4) r.chr_page_map_low[11*i +: 11] = pg[10:0];
                else r.chr_page_map_high[11*(i-4) +: 11] = pg[10:0];
            end
        end
        r.mirror_mode = m_mirror;
        r.irq_request = irq;
        return r;
    endfunction

    task automatic predict_request(input t_req rq);
        logic irq;
        logic [2:0] sel;
        irq = 1'b0;
        if (rq.req_type == REQ_WRITE) begin
            case (rq.cpu_address & ADDR_MASK)
                ADDR_BANK_SEL: m_bank_sel = rq.write_data;
                ADDR_BANK_DATA: begin
                    sel = m_bank_sel[2:0];
                    if (sel < 6) m_mirror = ~rq.write_data[7];
                    if (sel < 2) begin
                        if (m_chr_count != 0) begin
                            m_chr_bank[2*sel] = rq.write_data & 8'hFE;
                            m_chr_bank[2*sel+1] = (rq.write_data & 8'hFE) + 8'd1;
                        end
                    end else if (sel < 6) begin
                        if (m_chr_count != 0) m_chr_bank[sel+2] = rq.write_data;
                    end else if (sel == 6) begin
                        m_prg_first = rq.write_data;
                    end else begin
                        m_prg_second = rq.write_data;
                    end
                end
                ADDR_IRQ_LATCH: m_irq_cnt = rq.write_data;
                ADDR_IRQ_RELOAD: m_irq_reload = rq.write_data;
                ADDR_IRQ_OFF: m_irq_en = 1'b0;
                ADDR_IRQ_ON: m_irq_en = 1'b1;
                default: ;
            endcase
        end else if (m_irq_en && rq.scanline <= LAST_VISIBLE && rq.rendering_enabled) begin
            if (m_irq_cnt == 0) begin
                m_irq_cnt = m_irq_reload;
                irq = 1'b1;
            end else begin
                m_irq_cnt = m_irq_cnt - 8'd1;
            end
        end
        expected_maps.push_back(resolve_maps(irq));
    endtask

    task automatic send_request(input t_req rq, input bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) @(negedge i_clk);
        req_ch.data = rq;
        req_ch.valid = 1'b1;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        predict_request(rq);
        @(negedge i_clk);
        req_ch.valid = 1'b0;
    endtask

    function automatic t_req make_write(input logic [15:0] addr, input logic [7:0] d);
        t_req rq;
        rq.req_type = REQ_WRITE;
        rq.cpu_address = addr;
        rq.write_data = d;
        rq.scanline = 9'($urandom);
        rq.rendering_enabled = 1'($urandom);
        return rq;
    endfunction

    function automatic t_req make_tick(input logic [8:0] line, input logic rend);
        t_req rq;
        rq.req_type = REQ_TICK;
        rq.cpu_address = 16'($urandom);
        rq.write_data = 8'($urandom);
        rq.scanline = line;
        rq.rendering_enabled = rend;
        return rq;
    endfunction

    // register write address with random don't-care bits kept
    function automatic logic [15:0] reg_addr(input logic [15:0] base);
        return (16'($urandom) & ~ADDR_MASK) | base;
    endfunction

    task automatic wait_drained();
        while (expected_maps.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_config(input logic [CFG_INDEX_WIDTH-1:0] idx, input logic [7:0] v);
        wait_drained();
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == CFG_PRG_COUNT) m_prg_count = v;
        else m_chr_count = v;
    endtask

    task automatic test_directed();
        send_request(make_tick(9'd0, 1'b1));
        send_request(make_write(16'h0000, 8'hFF));
        send_request(make_write(16'hA001, 8'h55));
        send_request(make_write(16'hFFFF, 8'h00));
        for (int s = 0; s < 8; s++) begin
            send_request(make_write(ADDR_BANK_SEL, {s[1:0], 3'b000, s[2:0]}));
            send_request(make_write(ADDR_BANK_DATA, s[0] ? 8'hFF : 8'h80 + s[7:0]));
        end
        send_request(make_write(ADDR_IRQ_LATCH, 8'd1));
        send_request(make_write(ADDR_IRQ_RELOAD, 8'd255));
        send_request(make_write(ADDR_IRQ_ON, 8'h00));
        send_request(make_tick(9'd239, 1'b1));
        send_request(make_tick(9'd0, 1'b1));
        send_request(make_tick(9'd0, 1'b1));
        send_request(make_tick(9'd240, 1'b1));
        send_request(make_tick(9'd511, 1'b1));
        send_request(make_tick(9'd100, 1'b0));
        send_request(make_write(ADDR_IRQ_OFF, 8'hFF));
        send_request(make_tick(9'd10, 1'b1));
    endtask

    function automatic t_req random_request();
        int k;
        logic [15:0] bases [6];
        bases = '{ADDR_BANK_SEL, ADDR_BANK_DATA, ADDR_IRQ_LATCH,
                  ADDR_IRQ_RELOAD, ADDR_IRQ_OFF, ADDR_IRQ_ON};
        k = $urandom_range(0, 99);
        if (k < 40)
            return make_tick(($urandom_range(0, 7) == 0) ? 9'($urandom) : 9'($urandom_range(0, 239)),
                             ($urandom_range(0, 7) != 0));
        else if (k < 92)
            return make_write(reg_addr(bases[$urandom_range(0, 5)]),
                              ($urandom_range(0, 1) && k < 70) ? 8'($urandom_range(0, 12)) : 8'($urandom));
        else
            return make_write(16'($urandom), 8'($urandom));
    endfunction

    task automatic test_random(input int count);
        for (int n = 0; n < count; n++) send_request(random_request());
    endtask

    task automatic test_back_pressure();
        wait_drained();
        hold_off = 400;
        for (int n = 0; n < 20; n++) send_request(random_request(), 1);
        wait_drained();
    endtask

    task automatic test_config_sweep();
        logic [7:0] prg_vals [5];
        logic [7:0] chr_vals [5];
        prg_vals = '{8'd1, 8'd255, 8'd0, 8'd3, 8'd128};
        chr_vals = '{8'd1, 8'd255, 8'd0, 8'd5, 8'd32};
        for (int i = 0; i < 5; i++) begin
            write_config(CFG_PRG_COUNT, prg_vals[i]);
            write_config(CFG_CHR_COUNT, chr_vals[i]);
            test_random(300);
            if (i == 1) stall_enable = 1'b0;
            if (i == 2) stall_enable = 1'b1;
        end
    endtask

    // result receiver
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off > 0) begin
                rsp_ch.ready = 1'b0;
                while (hold_off > 0) begin
                    @(negedge i_clk);
                    hold_off--;
                end
            end
            stall = stall_enable ? $urandom_range(0, 5) : 0;
            if (stall_enable && $urandom_range(0, 3) == 0) stall = 0;
            if (stall > 0) begin
                rsp_ch.ready = 1'b0;
                repeat (stall - 1) @(negedge i_clk);
                continue;
            end
            rsp_ch.ready = 1'b1;
            @(posedge i_clk);
            while (!rsp_ch.valid) @(posedge i_clk);
            check_result(rsp_ch.data);
        end
    end

    task automatic check_result(input t_rsp got);
        t_rsp exp;
        if (expected_maps.size() == 0) begin
            $error("unexpected result transaction");
            n_errors++;
            return;
        end
        exp = expected_maps.pop_front();
        n_checked++;
        if (exp.irq_request) n_irqs++;
        if (got.prg_page_map !== exp.prg_page_map) begin
            $error("prg_page_map exp %h got %h", exp.prg_page_map, got.prg_page_map);
            n_errors++;
        end
        if (got.chr_page_map_low !== exp.chr_page_map_low) begin
            $error("chr_page_map_low exp %h got %h", exp.chr_page_map_low, got.chr_page_map_low);
            n_errors++;
        end
        if (got.chr_page_map_high !== exp.chr_page_map_high) begin
            $error("chr_page_map_high exp %h got %h",
                   exp.chr_page_map_high, got.chr_page_map_high);
            n_errors++;
        end
        if (got.mirror_mode !== exp.mirror_mode) begin
            $error("mirror_mode exp %b got %b", exp.mirror_mode, got.mirror_mode);
            n_errors++;
        end
        if (got.irq_request !== exp.irq_request) begin
            $error("irq_request exp %b got %b", exp.irq_request, got.irq_request);
            n_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial begin
        model_reset();
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        write_config(CFG_CHR_COUNT, 8'd2);
        test_directed();
        test_random(100);
        test_back_pressure();
        test_config_sweep();
        wait_drained();
        if (expected_maps.size() != 0) n_errors++;
        $display("checked %0d results (%0d irq pulses) over several PRG/CHR ROM sizes",
                 n_checked, n_irqs);
        if (n_errors == 0) $display("tb_top: done, clean");
        else $display("tb_top: done, errors");
        $finish;
    end
endmodule
